FILE: hw/rtl/mdrb_pkg.sv
package mdrb_pkg;

    // Shadow store geometry
    localparam int SHADOW_DEPTH = 16;
    localparam int SH_AW        = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;
    localparam logic [10:0] SHADOW_LIM = 11'(SHADOW_DEPTH);

    // Field widths
    localparam int OFS_W  = 13;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 45;
    localparam int CHAN_W = 8;

    // Item modes
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_DISP  = 2'd2,
        MODE_STAMP = 2'd3
    } t_mode;

    // Window offsets with a defined meaning
    localparam logic [OFS_W-1:0] OFS_ARMED      = 13'h1000;
    localparam logic [OFS_W-1:0] OFS_SIZE       = 13'h1004;
    localparam logic [OFS_W-1:0] OFS_RING_DB    = 13'h1008;
    localparam logic [OFS_W-1:0] OFS_START      = 13'h1010;
    localparam logic [OFS_W-1:0] OFS_DISP_PEND  = 13'h1014;
    localparam logic [OFS_W-1:0] OFS_STAMP_PEND = 13'h1018;
    localparam logic [OFS_W-1:0] OFS_SHARED     = 13'h101C;
    localparam logic [OFS_W-1:0] OFS_CHAN_DB    = 13'h1020;
    localparam logic [OFS_W-1:0] OFS_FRAME      = 13'h1030;
    localparam logic [OFS_W-1:0] OFS_CAP0       = 13'h1200;
    localparam logic [OFS_W-1:0] OFS_CAP1       = 13'h1210;
    localparam logic [OFS_W-1:0] OFS_CAP2       = 13'h1214;
    localparam logic [OFS_W-1:0] OFS_CAP3       = 13'h1218;
    localparam logic [OFS_W-1:0] OFS_CAP4       = 13'h121C;
    localparam logic [OFS_W-1:0] OFS_CAP5       = 13'h1228;
    localparam logic [OFS_W-1:0] OFS_VERSION    = 13'h122C;

    localparam logic [DATA_W-1:0] VERSION_VAL  = 32'd9;
    localparam logic [DATA_W-1:0] DEFAULT_SIZE = 32'h0001_0000;

    // Shadow store write port
    typedef struct packed {
        logic              wr_en;
        logic [SH_AW-1:0]  idx;
        logic [DATA_W-1:0] wdata;
    } t_shadow_req;

endpackage

FILE: hw/rtl/mdrb_in_if.sv
interface mdrb_in_if;
    import mdrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [OFS_W-1:0]  offset;
    logic [DATA_W-1:0] data;

    modport source (output valid, mode, offset, data, input ready);
    modport sink   (input valid, mode, offset, data, output ready);
endinterface

FILE: hw/rtl/mdrb_out_if.sv
interface mdrb_out_if;
    import mdrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              ring_enabled;
    logic [DATA_W-1:0] ring_bytes;
    logic [ADDR_W-1:0] ring_base_address;
    logic [DATA_W-1:0] shared_page_frame;
    logic [CHAN_W-1:0] channel_id;
    logic              ring_doorbell;
    logic              channel_doorbell;
    logic [DATA_W-1:0] doorbell_value;
    logic              unknown_write;

    modport source (output valid, read_data, ring_enabled, ring_bytes, ring_base_address,
                    shared_page_frame, channel_id, ring_doorbell, channel_doorbell,
                    doorbell_value, unknown_write, input ready);
    modport sink   (input valid, read_data, ring_enabled, ring_bytes, ring_base_address,
                    shared_page_frame, channel_id, ring_doorbell, channel_doorbell,
                    doorbell_value, unknown_write, output ready);
endinterface

FILE: hw/rtl/mdrb_shadow.sv
module mdrb_shadow (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mdrb_pkg::t_shadow_req                  i_req,
    input  logic [mdrb_pkg::SH_AW-1:0]             i_rd_idx,
    output logic [mdrb_pkg::DATA_W-1:0]            o_rd_data
);
    import mdrb_pkg::*;

    logic [DATA_W-1:0] r_words [SHADOW_DEPTH];

    // Reset the mirror (word zero reads one), then take writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SHADOW_DEPTH; i++) begin
                r_words[i] <= (i == 0) ? DATA_W'(1) : '0;
            end
        end else if (i_req.wr_en) begin
            r_words[i_req.idx] <= i_req.wdata;
        end
    end

    // Single read port
    assign o_rd_data = r_words[i_rd_idx];

endmodule

FILE: hw/rtl/mmio_doorbell_register_block.sv
// Register window of a paravirtual ring device (byte offsets 0x1000-0x1FFF). Each transfer
// on i_req is a bus write, a bus read, or an OR into the display or stamp pending mask, and
// yields exactly one transfer on o_rsp with the read value, the ring control registers as
// they stand after the item, and the doorbell/unknown-offset pulses. An item is captured in
// an input register and then decoded against the register file, which loads the result
// register. One item per cycle is sustained as long as o_rsp takes results; a stalled
// result register holds the input register full and then drops i_req.ready. Writes at
// offsets 0x1000-0x103F are mirrored into a 16-word shadow whose word zero resets to one.
// Reading a pending mask clears it.
module mmio_doorbell_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdrb_in_if.sink     i_req,
    mdrb_out_if.source  o_rsp
);
    import mdrb_pkg::*;

    // Input register
    logic              r_in_vld;
    logic [1:0]        r_in_mode;
    logic [OFS_W-1:0]  r_in_ofs;
    logic [DATA_W-1:0] r_in_data;

    // Register file
    logic              r_armed,      n_armed;
    logic [DATA_W-1:0] r_size,       n_size;
    logic [DATA_W-1:0] r_start,      n_start;
    logic [DATA_W-1:0] r_frame,      n_frame;
    logic [ADDR_W-1:0] r_base,       n_base;
    logic [DATA_W-1:0] r_shared,     n_shared;
    logic [CHAN_W-1:0] r_chan,       n_chan;
    logic [DATA_W-1:0] r_disp_pend,  n_disp_pend;
    logic [DATA_W-1:0] r_stamp_pend, n_stamp_pend;

    // Result register
    logic              r_out_vld;
    logic [DATA_W-1:0] r_rd_data,    n_rd_data;
    logic              r_ring_db,    n_ring_db;
    logic              r_chan_db,    n_chan_db;
    logic [DATA_W-1:0] r_db_val,     n_db_val;
    logic              r_unknown,    n_unknown;

    logic              adv;
    logic              proc;
    logic              in_rdy;
    logic              in_xfer;
    t_mode             mode;
    logic [9:0]        word_idx;
    logic              slot_ok;
    logic [DATA_W-1:0] shadow_rd;
    t_shadow_req       shadow_req;

    // Handshake: result stage advances when empty or taken
    assign adv     = !r_out_vld || o_rsp.ready;
    assign proc    = r_in_vld && adv;
    assign in_rdy  = !r_in_vld || adv;
    assign in_xfer = i_req.valid && in_rdy;
    assign i_req.ready = in_rdy;

    // Capture the incoming transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_mode <= i_req.mode;
            r_in_ofs  <= i_req.offset;
            r_in_data <= i_req.data;
        end
    end

    // Shadow word decode
    assign mode     = t_mode'(r_in_mode);
    assign word_idx = r_in_ofs[11:2];
    assign slot_ok  = r_in_ofs[12] && ({1'b0, word_idx} < SHADOW_LIM);

    assign shadow_req.wr_en = proc && (mode == MODE_WRITE) && slot_ok;
    assign shadow_req.idx   = word_idx[SH_AW-1:0];
    assign shadow_req.wdata = r_in_data;

    mdrb_shadow u_shadow (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (shadow_req),
        .i_rd_idx  (word_idx[SH_AW-1:0]),
        .o_rd_data (shadow_rd)
    );

    // Base address from the new frame/start pair
    assign n_base = ADDR_W'({n_frame, 12'h000}) + ADDR_W'(n_start);

    // Decode one item against the register file
    always_comb begin
        n_armed      = r_armed;
        n_size       = r_size;
        n_start      = r_start;
        n_frame      = r_frame;
        n_shared     = r_shared;
        n_chan       = r_chan;
        n_disp_pend  = r_disp_pend;
        n_stamp_pend = r_stamp_pend;
        n_rd_data    = '0;
        n_ring_db    = 1'b0;
        n_chan_db    = 1'b0;
        n_db_val     = '0;
        n_unknown    = 1'b0;
        case (mode)
            MODE_WRITE: begin
                case (r_in_ofs)
                    OFS_ARMED:   n_armed = (r_in_data != '0);
                    OFS_SIZE:    n_size  = (r_in_data != '0) ? r_in_data : DEFAULT_SIZE;
                    OFS_RING_DB: begin
                        n_ring_db = 1'b1;
                        n_db_val  = r_in_data;
                    end
                    OFS_START:   n_start  = r_in_data;
                    OFS_SHARED:  n_shared = r_in_data;
                    OFS_CHAN_DB: begin
                        n_chan    = r_in_data[CHAN_W-1:0];
                        n_chan_db = 1'b1;
                        n_db_val  = r_in_data;
                    end
                    OFS_FRAME: begin
                        n_frame = r_in_data;
                        if (r_size == '0) begin
                            n_size = DEFAULT_SIZE;
                        end
                    end
                    OFS_CAP0, OFS_CAP1, OFS_CAP2,
                    OFS_CAP3, OFS_CAP4, OFS_CAP5: ;
                    default:     n_unknown = 1'b1;
                endcase
            end
            MODE_READ: begin
                if (r_in_ofs == OFS_VERSION) begin
                    n_rd_data = VERSION_VAL;
                end else if (r_in_ofs == OFS_DISP_PEND) begin
                    n_rd_data   = r_disp_pend;
                    n_disp_pend = '0;
                end else if (r_in_ofs == OFS_STAMP_PEND) begin
                    n_rd_data    = r_stamp_pend;
                    n_stamp_pend = '0;
                end else if (slot_ok) begin
                    n_rd_data = shadow_rd;
                end
            end
            MODE_DISP:  n_disp_pend  = r_disp_pend | r_in_data;
            MODE_STAMP: n_stamp_pend = r_stamp_pend | r_in_data;
            default: ;
        endcase
    end

    // Update the register file as each item completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_size       <= '0;
            r_start      <= '0;
            r_frame      <= '0;
            r_base       <= '0;
            r_shared     <= '0;
            r_chan       <= '0;
            r_disp_pend  <= '0;
            r_stamp_pend <= '0;
        end else if (proc) begin
            r_armed      <= n_armed;
            r_size       <= n_size;
            r_start      <= n_start;
            r_frame      <= n_frame;
            r_base       <= n_base;
            r_shared     <= n_shared;
            r_chan       <= n_chan;
            r_disp_pend  <= n_disp_pend;
            r_stamp_pend <= n_stamp_pend;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_rd_data <= n_rd_data;
            r_ring_db <= n_ring_db;
            r_chan_db <= n_chan_db;
            r_db_val  <= n_db_val;
            r_unknown <= n_unknown;
        end
    end

    // Drive the result transfer; control fields reflect state after the item
    assign o_rsp.valid             = r_out_vld;
    assign o_rsp.read_data         = r_rd_data;
    assign o_rsp.ring_enabled      = r_armed;
    assign o_rsp.ring_bytes        = r_size;
    assign o_rsp.ring_base_address = r_base;
    assign o_rsp.shared_page_frame = r_shared;
    assign o_rsp.channel_id        = r_chan;
    assign o_rsp.ring_doorbell     = r_ring_db;
    assign o_rsp.channel_doorbell  = r_chan_db;
    assign o_rsp.doorbell_value    = r_db_val;
    assign o_rsp.unknown_write     = r_unknown;

endmodule

FILE: hw/rtl/mdrb_chk.sv
module mdrb_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_read_data,
    input logic        i_ring_doorbell,
    input logic        i_channel_doorbell,
    input logic [31:0] i_doorbell_value,
    input logic        i_unknown_write
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_read_data)
            && $stable(i_doorbell_value))
        else $error("stalled result changed");

    // At most one of doorbell and unknown-offset pulses per result
    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> $onehot0({i_ring_doorbell, i_channel_doorbell, i_unknown_write}))
        else $error("conflicting write pulses");

    // Doorbell value only travels with a doorbell pulse
    a_db_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_ring_doorbell && !i_channel_doorbell |-> i_doorbell_value == '0)
        else $error("doorbell value without pulse");

    // A write result never carries read data
    a_write_no_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_ring_doorbell || i_channel_doorbell || i_unknown_write)
            |-> i_read_data == '0)
        else $error("write result with read data");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind mmio_doorbell_register_block mdrb_chk u_mdrb_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_read_data        (o_rsp.read_data),
    .i_ring_doorbell    (o_rsp.ring_doorbell),
    .i_channel_doorbell (o_rsp.channel_doorbell),
    .i_doorbell_value   (o_rsp.doorbell_value),
    .i_unknown_write    (o_rsp.unknown_write)
);

FILE: dv/mmio_doorbell_register_block_checker.sv
`timescale 1ns / 100ps

module mmio_doorbell_register_block_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mdrb_in_if   i_req,
    mdrb_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending_count
);
    import mdrb_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              ring_enabled;
        logic [DATA_W-1:0] ring_bytes;
        logic [ADDR_W-1:0] ring_base_address;
        logic [DATA_W-1:0] shared_page_frame;
        logic [CHAN_W-1:0] channel_id;
        logic              ring_doorbell;
        logic              channel_doorbell;
        logic [DATA_W-1:0] doorbell_value;
        logic              unknown_write;
    } t_window_rsp;

    // Mirror of the register window
    logic [DATA_W-1:0] shadow_mirror [SHADOW_DEPTH];
    logic              armed_q;
    logic [DATA_W-1:0] size_q;
    logic [DATA_W-1:0] start_ofs_q;
    logic [DATA_W-1:0] frame_q;
    logic [ADDR_W-1:0] base_addr_q;
    logic [DATA_W-1:0] shared_frame_q;
    logic [CHAN_W-1:0] chan_q;
    logic [DATA_W-1:0] disp_pend_q;
    logic [DATA_W-1:0] stamp_pend_q;

    t_window_rsp rsp_fifo [$];
    int          mismatch_total = 0;

    // Apply one access to the mirror and return the response it must produce
    function automatic t_window_rsp predict_window_access(t_mode mode, logic [OFS_W-1:0] ofs,
                                                          logic [DATA_W-1:0] wdata);
        t_window_rsp rsp;
        logic        has_shadow;
        int          word;
        rsp        = '0;
        word       = int'(ofs[11:2]);
        has_shadow = ofs[12] && (word < SHADOW_DEPTH);
        case (mode)
            MODE_WRITE: begin
                if (has_shadow) begin
                    shadow_mirror[word[SH_AW-1:0]] = wdata;
                end
                case (ofs)
                    OFS_ARMED: armed_q = (wdata != '0);
                    OFS_SIZE:  size_q = (wdata != '0) ? wdata : DEFAULT_SIZE;
                    OFS_RING_DB: begin
                        rsp.ring_doorbell  = 1'b1;
                        rsp.doorbell_value = wdata;
                    end
                    OFS_START: begin
                        start_ofs_q = wdata;
                        base_addr_q = (ADDR_W'(frame_q) << 12) + ADDR_W'(start_ofs_q);
                    end
                    OFS_SHARED: shared_frame_q = wdata;
                    OFS_CHAN_DB: begin
                        chan_q                = wdata[CHAN_W-1:0];
                        rsp.channel_doorbell = 1'b1;
                        rsp.doorbell_value   = wdata;
                    end
                    OFS_FRAME: begin
                        frame_q     = wdata;
                        base_addr_q = (ADDR_W'(frame_q) << 12) + ADDR_W'(start_ofs_q);
                        if (size_q == '0) begin
                            size_q = DEFAULT_SIZE;
                        end
                    end
                    OFS_CAP0, OFS_CAP1, OFS_CAP2, OFS_CAP3, OFS_CAP4, OFS_CAP5: ;
                    default: rsp.unknown_write = 1'b1;
                endcase
            end
            MODE_READ: begin
                if (ofs == OFS_VERSION) begin
                    rsp.read_data = VERSION_VAL;
                end else if (ofs == OFS_DISP_PEND) begin
                    rsp.read_data = disp_pend_q;
                    disp_pend_q   = '0;
                end else if (ofs == OFS_STAMP_PEND) begin
                    rsp.read_data = stamp_pend_q;
                    stamp_pend_q  = '0;
                end else if (has_shadow) begin
                    rsp.read_data = shadow_mirror[word[SH_AW-1:0]];
                end
            end
            MODE_DISP: disp_pend_q = disp_pend_q | wdata;
            default:   stamp_pend_q = stamp_pend_q | wdata;
        endcase
        rsp.ring_enabled      = armed_q;
        rsp.ring_bytes        = size_q;
        rsp.ring_base_address = base_addr_q;
        rsp.shared_page_frame = shared_frame_q;
        rsp.channel_id        = chan_q;
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    // Compare completed transfers, then queue the prediction for a new one
    always @(posedge i_clk) begin : monitor
        t_window_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < SHADOW_DEPTH; i++) begin
                shadow_mirror[i] = '0;
            end
            shadow_mirror[0] = 32'd1;
            armed_q        = 1'b0;
            size_q         = '0;
            start_ofs_q    = '0;
            frame_q        = '0;
            base_addr_q    = '0;
            shared_frame_q = '0;
            chan_q         = '0;
            disp_pend_q    = '0;
            stamp_pend_q   = '0;
            rsp_fifo.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_fifo.size() == 0) begin
                    $display("%0t ns: response transfer with none expected, read_data %0h",
                             $time, i_rsp.read_data);
                    mismatch_total++;
                end else begin
                    want = rsp_fifo.pop_front();
                    check_field("read_data", 64'(i_rsp.read_data), 64'(want.read_data));
                    check_field("ring_enabled", 64'(i_rsp.ring_enabled),
                                64'(want.ring_enabled));
                    check_field("ring_bytes", 64'(i_rsp.ring_bytes), 64'(want.ring_bytes));
                    check_field("ring_base_address", 64'(i_rsp.ring_base_address),
                                64'(want.ring_base_address));
                    check_field("shared_page_frame", 64'(i_rsp.shared_page_frame),
                                64'(want.shared_page_frame));
                    check_field("channel_id", 64'(i_rsp.channel_id), 64'(want.channel_id));
                    check_field("ring_doorbell", 64'(i_rsp.ring_doorbell),
                                64'(want.ring_doorbell));
                    check_field("channel_doorbell", 64'(i_rsp.channel_doorbell),
                                64'(want.channel_doorbell));
                    check_field("doorbell_value", 64'(i_rsp.doorbell_value),
                                64'(want.doorbell_value));
                    check_field("unknown_write", 64'(i_rsp.unknown_write),
                                64'(want.unknown_write));
                end
            end
            if (i_req.valid && i_req.ready) begin
                rsp_fifo.push_back(predict_window_access(t_mode'(i_req.mode), i_req.offset,
                                                         i_req.data));
            end
        end
        o_fail_count    <= mismatch_total;
        o_pending_count <= rsp_fifo.size();
    end

endmodule

FILE: dv/mmio_doorbell_register_block_test.sv
`timescale 1ns / 100ps

module mmio_doorbell_register_block_test;
    import mdrb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mdrb_in_if  req_if ();
    mdrb_out_if rsp_if ();

    int   src_idle_pct  = 8;
    int   sink_idle_pct = 54;
    logic long_hold_req = 1'b0;
    int   fail_count;
    int   pending_count;

    logic [OFS_W-1:0] decoded_ofs [16] = '{
        OFS_ARMED, OFS_SIZE, OFS_RING_DB, OFS_START, OFS_DISP_PEND, OFS_STAMP_PEND,
        OFS_SHARED, OFS_CHAN_DB, OFS_FRAME, OFS_CAP0, OFS_CAP1, OFS_CAP2, OFS_CAP3,
        OFS_CAP4, OFS_CAP5, OFS_VERSION
    };

    mmio_doorbell_register_block dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    mmio_doorbell_register_block_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_if),
        .i_rsp           (rsp_if),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response side: random backpressure, plus one long hold on request
    initial begin : rsp_sink
        int  hold_left;
        logic hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one access and hold it until the transfer completes
    task automatic send_access(t_mode mode, logic [OFS_W-1:0] ofs, logic [DATA_W-1:0] wdata);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.mode   <= mode;
        req_if.offset <= ofs;
        req_if.data   <= wdata;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Stop offering and wait for every outstanding response
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_accesses(int count);
        t_mode             mode;
        logic [OFS_W-1:0]  ofs;
        logic [DATA_W-1:0] wdata;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                mode = MODE_WRITE;
            end else if (pick < 80) begin
                mode = MODE_READ;
            end else if (pick < 90) begin
                mode = MODE_DISP;
            end else begin
                mode = MODE_STAMP;
            end
            case ($urandom_range(9))
                0, 1, 2: ofs = decoded_ofs[$urandom_range(15)];
                3, 4, 5: ofs = OFS_ARMED + OFS_W'($urandom_range(63));
                6, 7:    ofs = OFS_ARMED + OFS_W'($urandom_range(4095));
                default: ofs = OFS_W'($urandom_range(8191));
            endcase
            case ($urandom_range(7))
                0:       wdata = '0;
                1:       wdata = '1;
                2:       wdata = DATA_W'($urandom_range(255));
                default: wdata = $urandom;
            endcase
            send_access(mode, ofs, wdata);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.mode   = MODE_WRITE;
        req_if.offset = '0;
        req_if.data   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values, version word and empty pending masks
        send_access(MODE_READ, OFS_ARMED, '0);
        send_access(MODE_READ, OFS_VERSION, '0);
        send_access(MODE_READ, OFS_DISP_PEND, '0);
        // Pending masks: set, read back, confirm clear on read
        send_access(MODE_DISP, 13'h0000, '1);
        send_access(MODE_STAMP, 13'h1FFF, 32'hA5A5_5A5A);
        send_access(MODE_READ, OFS_DISP_PEND, '0);
        send_access(MODE_READ, OFS_DISP_PEND, '0);
        send_access(MODE_READ, OFS_STAMP_PEND, '0);
        // Ring control: frame with zero size, zero size, all-ones frame and start
        send_access(MODE_WRITE, OFS_ARMED, '0);
        send_access(MODE_WRITE, OFS_FRAME, '1);
        send_access(MODE_WRITE, OFS_SIZE, '0);
        send_access(MODE_WRITE, OFS_START, '1);
        send_access(MODE_WRITE, OFS_SIZE, '1);
        send_access(MODE_WRITE, OFS_ARMED, '1);
        // Doorbells and shared frame
        send_access(MODE_WRITE, OFS_RING_DB, 32'hDEAD_BEEF);
        send_access(MODE_WRITE, OFS_CHAN_DB, 32'h1234_56AB);
        send_access(MODE_WRITE, OFS_SHARED, 32'h8000_0001);
        // Capability offsets, and pending offsets that are not writable
        send_access(MODE_WRITE, OFS_CAP0, 32'h5555_5555);
        send_access(MODE_WRITE, OFS_CAP5, 32'hAAAA_AAAA);
        send_access(MODE_WRITE, OFS_DISP_PEND, 32'h0F0F_0F0F);
        // Unaligned shadow accesses, top shadow word, outside the window
        send_access(MODE_WRITE, 13'h103F, 32'hCAFE_F00D);
        send_access(MODE_READ, 13'h103D, '0);
        send_access(MODE_WRITE, 13'h1003, 32'h0000_0077);
        send_access(MODE_READ, 13'h1002, '0);
        send_access(MODE_WRITE, 13'h0FFC, '1);
        send_access(MODE_READ, 13'h1FFF, '0);
        send_access(MODE_READ, 13'h0000, '0);

        // Slow receiver, with one long hold while the sender keeps offering
        send_random_accesses(100);
        long_hold_req = 1'b1;
        send_random_accesses(600);
        drain_responses();

        // Slow sender
        src_idle_pct  = 54;
        sink_idle_pct = 8;
        send_random_accesses(650);
        drain_responses();

        // Full rate both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random_accesses(650);
        drain_responses();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("mmio_doorbell_register_block: match");
        end else begin
            $display("mmio_doorbell_register_block: mismatch");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("mmio_doorbell_register_block: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mdrb_pkg.sv
hw/rtl/mdrb_in_if.sv
hw/rtl/mdrb_out_if.sv
hw/rtl/mdrb_shadow.sv
hw/rtl/mmio_doorbell_register_block.sv
hw/rtl/mdrb_chk.sv
dv/mmio_doorbell_register_block_checker.sv
dv/mmio_doorbell_register_block_test.sv
